FILE: hdl/scaled_dual_matrix_product_defines.svh
// Assertion macros for the scaled dual matrix product RTL.
`ifndef SCALED_DUAL_MATRIX_PRODUCT_DEFINES_SVH
`define SCALED_DUAL_MATRIX_PRODUCT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdmp assertion failed");

// Next-cycle implication, checked outside reset.
`define SDMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdmp assertion failed");

`endif

FILE: hdl/sdmp_pkg.sv
// Types and constants of the scaled dual matrix product.
`timescale 1ns / 1ps
package sdmp_pkg;

  localparam int SIZE_W  = 5;
  localparam int VAL_W   = 8;
  localparam int IDX_W   = 4;
  localparam int RES_W   = 53;
  localparam int SCALE_W = 33;
  localparam int STAT_W  = 2;
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = 2 * VAL_W;
  localparam int N4_W    = 4 * SIZE_W;
  localparam int PROD_W  = DIFF_W + N4_W;
  localparam int NUM_W   = PROD_W + FRAC_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_READY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_SUM  = 2'd2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 5'd4;
  localparam logic [SCALE_W-1:0] SCALE_MAX  = '1;
  localparam logic [RES_W-1:0]   RESULT_MAX = '1;

  typedef struct packed {
    logic              opcode;
    logic [VAL_W-1:0]  a_value;
    logic [VAL_W-1:0]  b_value;
    logic [VAL_W-1:0]  c_value;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
  } in_word_t;

  typedef struct packed {
    logic [RES_W-1:0]   result_value;
    logic [SCALE_W-1:0] scale_factor;
    logic [STAT_W-1:0]  status;
  } out_word_t;

  // Classified command held between front and back.
  typedef struct packed {
    logic              is_read;
    logic [VAL_W-1:0]  a_value;
    logic [VAL_W-1:0]  b_value;
    logic [VAL_W-1:0]  c_value;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
  } cmd_t;

endpackage

FILE: hdl/sdmp_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sdmp_divider import sdmp_pkg::*; #(
  parameter int NW = 52,
  parameter int DW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    fits    = shifted >= {1'b0, den_r};
    rem_nxt = fits ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/sdmp_cmd_queue.sv
// Front end: accept input words, classify them and queue them for the engine.
`timescale 1ns / 1ps
module sdmp_cmd_queue import sdmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_word_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;
  cmd_t             cls;

  always_comb begin
    cls.is_read   = (in_data.opcode == OP_READ);
    cls.a_value   = in_data.a_value;
    cls.b_value   = in_data.b_value;
    cls.c_value   = in_data.c_value;
    cls.row_index = in_data.row_index;
    cls.col_index = in_data.col_index;
  end

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= cls;
  end

endmodule

FILE: hdl/sdmp_engine.sv
// Back end: element stores, set statistics, scale computation and dot products.
`timescale 1ns / 1ps
`include "scaled_dual_matrix_product_defines.svh"
module sdmp_engine import sdmp_pkg::*; #(
  parameter int MAX_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_size,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              out_valid,
  output out_word_t         out_data
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = $clog2(255 * DEPTH + 1);
  localparam int DEN_W = 2 * SUM_W;
  localparam int ACC_W = 2 * VAL_W + $clog2(MAX_SIZE + 1);
  localparam int SCL_W = SCALE_W + ACC_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SC1    = 4'd1;
  localparam logic [3:0] ST_SC2    = 4'd2;
  localparam logic [3:0] ST_SC3    = 4'd3;
  localparam logic [3:0] ST_DIVS   = 4'd4;
  localparam logic [3:0] ST_DIVW   = 4'd5;
  localparam logic [3:0] ST_RRUN   = 4'd6;
  localparam logic [3:0] ST_RDRAIN = 4'd7;
  localparam logic [3:0] ST_RMUL   = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  logic [VAL_W-1:0] a_mem [DEPTH];
  logic [VAL_W-1:0] b_mem [DEPTH];
  logic [VAL_W-1:0] c_mem [DEPTH];

  logic [3:0]          state_r;
  logic [SIZE_W-1:0]   n_r, cfg_n;
  logic [2*SIZE_W-1:0] n2;
  logic [CW-1:0]       count_r, cnt0, cnt1;
  logic [SUM_W-1:0]    sum_a_r, sum_b_r, sa0, sb0;
  logic [VAL_W-1:0]    max_a_r, min_a_r, max_b_r, min_b_r;
  logic [VAL_W-1:0]    mxa0, mna0, mxb0, mnb0;
  logic [SCALE_W-1:0]  scale_r, q_eff;
  logic                restart, zero_sum, set_full;

  logic [DIFF_W-1:0]   hi_r, lo_r, diff_r;
  logic [N4_W-1:0]     n4_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DEN_W-1:0]    den_r;
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_quo;

  logic [SIZE_W-1:0]   r_sat, c_sat, k_r;
  logic [AW-1:0]       addr_ar_r, addr_bk_r, addr_bc_r;
  logic [VAL_W-1:0]    rd_a_r, rd_bk_r, rd_bc_r, rd_c_r;
  logic                rv_r, pv_r, nr_r;
  logic [DIFF_W-1:0]   pab_r, pcb_r;
  logic [ACC_W-1:0]    ab_acc_r, cb_acc_r;
  logic [SCL_W-1:0]    scaled_r;
  logic [63:0]         sc64, sat1, sum64;
  logic [RES_W-1:0]    res_val;
  logic                emit_go, mem_we;
  logic                out_valid_r;
  out_word_t           out_data_r, out_nxt;

  assign n2       = n_r * n_r;
  assign restart  = 32'(count_r) >= 32'(n2);
  assign set_full = 32'(count_r) == 32'(n2);
  assign zero_sum = (sum_a_r == '0) || (sum_b_r == '0);
  assign q_eff    = zero_sum ? '0 : scale_r;

  // Clamp the written size into 1..MAX_SIZE.
  always_comb begin
    cfg_n = cfg_size;
    if (cfg_size == '0) cfg_n = SIZE_W'(1);
    if (32'(cfg_size) > MAX_SIZE) cfg_n = SIZE_W'(MAX_SIZE);
  end

  // Load bookkeeping: a load after a full set starts from an empty one.
  always_comb begin
    cnt0 = restart ? '0 : count_r;
    cnt1 = cnt0 + 1'b1;
    sa0  = restart ? '0 : sum_a_r;
    sb0  = restart ? '0 : sum_b_r;
    mxa0 = restart ? '0 : max_a_r;
    mna0 = restart ? '1 : min_a_r;
    mxb0 = restart ? '0 : max_b_r;
    mnb0 = restart ? '1 : min_b_r;
  end

  always_comb begin
    r_sat = {1'b0, cmd.row_index};
    c_sat = {1'b0, cmd.col_index};
    if (r_sat >= n_r) r_sat = n_r - 1'b1;
    if (c_sat >= n_r) c_sat = n_r - 1'b1;
  end

  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign mem_we    = cmd_pop && !cmd.is_read;
  assign div_start = (state_r == ST_DIVS) && (den_r != '0);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || pop);

  always_comb begin
    sc64  = 64'(scaled_r);
    sat1  = (sc64 > 64'(RESULT_MAX)) ? 64'(RESULT_MAX) : sc64;
    sum64 = sat1 + (64'(cb_acc_r) << FRAC_W);
    res_val = (sum64 > 64'(RESULT_MAX)) ? RESULT_MAX : sum64[RES_W-1:0];
    if (nr_r) begin
      out_nxt.result_value = '0;
      out_nxt.scale_factor = '0;
      out_nxt.status       = STAT_NOT_READY;
    end else begin
      out_nxt.result_value = res_val;
      out_nxt.scale_factor = q_eff;
      out_nxt.status       = zero_sum ? STAT_ZERO_SUM : STAT_OK;
    end
  end

  sdmp_divider #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({prod_r, {FRAC_W{1'b0}}}),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Stores: one write port, reads registered every cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      a_mem[cnt0[AW-1:0]] <= cmd.a_value;
      b_mem[cnt0[AW-1:0]] <= cmd.b_value;
      c_mem[cnt0[AW-1:0]] <= cmd.c_value;
    end
    rd_a_r  <= a_mem[addr_ar_r];
    rd_c_r  <= c_mem[addr_ar_r];
    rd_bk_r <= b_mem[addr_bk_r];
    rd_bc_r <= b_mem[addr_bc_r];
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    hi_r     <= max_a_r * max_b_r;
    lo_r     <= min_a_r * min_b_r;
    diff_r   <= (hi_r >= lo_r) ? hi_r - lo_r : '0;
    n4_r     <= N4_W'(n2 * n2);
    prod_r   <= diff_r * n4_r;
    den_r    <= sum_a_r * sum_b_r;
    pab_r    <= rd_a_r * rd_bk_r;
    pcb_r    <= rd_c_r * rd_bc_r;
    scaled_r <= q_eff * ab_acc_r;
    if (emit_go) out_data_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= SIZE_RESET;
      count_r     <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      max_a_r     <= '0;
      min_a_r     <= '1;
      max_b_r     <= '0;
      min_b_r     <= '1;
      scale_r     <= '0;
      rv_r        <= 1'b0;
      pv_r        <= 1'b0;
      nr_r        <= 1'b0;
      k_r         <= '0;
      addr_ar_r   <= '0;
      addr_bk_r   <= '0;
      addr_bc_r   <= '0;
      ab_acc_r    <= '0;
      cb_acc_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= (state_r == ST_RRUN);
      pv_r <= rv_r;
      if (pv_r) begin
        ab_acc_r <= ab_acc_r + ACC_W'(pab_r);
        cb_acc_r <= cb_acc_r + ACC_W'(pcb_r);
      end
      if (emit_go) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;

      if (cfg_we) begin
        n_r     <= cfg_n;
        count_r <= '0;
        sum_a_r <= '0;
        sum_b_r <= '0;
        max_a_r <= '0;
        min_a_r <= '1;
        max_b_r <= '0;
        min_b_r <= '1;
        scale_r <= '0;
      end else begin
        case (state_r)
          ST_IDLE: begin
            if (cmd_pop && !cmd.is_read) begin
              count_r <= cnt1;
              sum_a_r <= sa0 + SUM_W'(cmd.a_value);
              sum_b_r <= sb0 + SUM_W'(cmd.b_value);
              max_a_r <= (cmd.a_value > mxa0) ? cmd.a_value : mxa0;
              min_a_r <= (cmd.a_value < mna0) ? cmd.a_value : mna0;
              max_b_r <= (cmd.b_value > mxb0) ? cmd.b_value : mxb0;
              min_b_r <= (cmd.b_value < mnb0) ? cmd.b_value : mnb0;
              if (restart) scale_r <= '0;
              if (32'(cnt1) == 32'(n2)) state_r <= ST_SC1;
            end else if (cmd_pop) begin
              nr_r <= !set_full;
              if (!set_full) begin
                state_r <= ST_EMIT;
              end else begin
                addr_ar_r <= AW'(r_sat * n_r);
                addr_bc_r <= AW'(c_sat * n_r);
                addr_bk_r <= AW'(c_sat);
                k_r       <= '0;
                ab_acc_r  <= '0;
                cb_acc_r  <= '0;
                state_r   <= ST_RRUN;
              end
            end
          end
          ST_SC1:  state_r <= ST_SC2;
          ST_SC2:  state_r <= ST_SC3;
          ST_SC3:  state_r <= ST_DIVS;
          ST_DIVS: begin
            if (den_r == '0) begin
              scale_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_DIVW;
            end
          end
          ST_DIVW: begin
            if (div_done) begin
              scale_r <= (div_quo > NUM_W'(SCALE_MAX)) ? SCALE_MAX
                                                       : div_quo[SCALE_W-1:0];
              state_r <= ST_IDLE;
            end
          end
          ST_RRUN: begin
            addr_ar_r <= addr_ar_r + 1'b1;
            addr_bc_r <= addr_bc_r + 1'b1;
            addr_bk_r <= addr_bk_r + AW'(n_r);
            k_r       <= k_r + 1'b1;
            if (k_r == n_r - 1'b1) state_r <= ST_RDRAIN;
          end
          ST_RDRAIN: begin
            if (!rv_r && !pv_r) state_r <= ST_RMUL;
          end
          ST_RMUL: state_r <= ST_EMIT;
          ST_EMIT: begin
            if (emit_go) state_r <= ST_IDLE;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SDMP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= 32'(n2))
  `SDMP_ASSERT_IMPL(a_ext_order, clk, rst_n, count_r != '0, min_a_r <= max_a_r && min_b_r <= max_b_r)
  `SDMP_ASSERT_NEXT(a_div_exit, clk, rst_n, state_r == ST_DIVW && div_done && !cfg_we, state_r == ST_IDLE)
  `SDMP_ASSERT_IMPL(a_read_drained, clk, rst_n, state_r == ST_RMUL, !rv_r && !pv_r)

endmodule

FILE: hdl/scaled_dual_matrix_product.sv
// Top level of the scaled dual matrix product.
`timescale 1ns / 1ps
// Loads A, B and C element by element in row-major order and answers reads with
// R = q*(A*B) + C*transpose(B) at one position, 16 fraction bits, where
// q = (maxA*maxB - minA*minB)*n^4/(sumA*sumB) in unsigned Q17.16. A front queue
// of four words takes input while the engine works and while a result word waits
// on the output register. The engine handles one word at a time. The load that
// completes a set also computes the scale, unless a sum is zero, with the 52-bit
// divider that yields one quotient bit a cycle; a read runs two dot products that
// walk the stores one element a cycle (the B store gives two reads a cycle). A read
// before the set is complete returns status 1. Writing matrix_size (0 acts as 1,
// values above MAX_SIZE act as MAX_SIZE) empties the set; write it only while the
// block is idle.
module scaled_dual_matrix_product import sdmp_pkg::*; #(
  parameter int MAX_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_word_t          in_data,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic cmd_valid, cmd_pop, out_valid;
  cmd_t cmd;

  // Size writes are taken at once.
  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  sdmp_cmd_queue u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sdmp_engine #(.MAX_SIZE(MAX_SIZE)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
